/* design/gcl_pkg.sv */
// ----------------------------------------------------------------------------
// Gray centroid line centre: shared package
// Register indexes, field widths, controller states and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package gcl_pkg;

	localparam int GRAY_W   = 8;
	localparam int POS_W    = 12;
	localparam int LINE_W   = 12;
	localparam int ROI_W    = 13;
	localparam int PROD_W   = GRAY_W + POS_W;
	localparam int WSUM_W   = 33;
	localparam int GSUM_W   = 20;
	localparam int CENT_W   = 20;
	localparam int CFG_IDX_W = 3;

	// Positions at or beyond this length never qualify.
	localparam logic [16:0] MAX_LINE_LENGTH = 17'd4096;

	// One restoring step per quotient bit.
	localparam int DIV_STEPS = CENT_W;
	localparam int CNT_W     = $clog2(DIV_STEPS + 1);

	localparam logic [ROI_W-1:0] ROI_HIGH_RESET = 13'd4096;

	localparam logic [CFG_IDX_W-1:0] REG_GRAY_THRESHOLD  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCAN_BY_COLUMNS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROI_X_LOW       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROI_X_HIGH      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROI_Y_LOW       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ROI_Y_HIGH      = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_DIVIDE = 3'b010,
		ST_DONE   = 3'b100
	} gcl_state_t;

	typedef struct packed {
		logic load;   // capture the line sums into the divider
		logic first;  // range test of the quotient, divider set-up
		logic step;   // one restoring division step
		logic emit;   // move the quotient to the output register
	} gcl_cmd_t;

	typedef struct packed {
		logic line_done;   // last item of a line sits in the first stage
		logic has_result;  // at least one pixel of that line qualified
		logic out_free;    // output register can take a result
	} gcl_stat_t;

endpackage

/* design/gcl_ctrl.sv */
// ----------------------------------------------------------------------------
// Gray centroid line centre: controller
// Sequences the per-line division and gates the pixel stream while it runs.
// ----------------------------------------------------------------------------
module gcl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  gcl_pkg::gcl_stat_t stat,
	output gcl_pkg::gcl_cmd_t  cmd,
	output logic              in_ready
);

	gcl_pkg::gcl_state_t            state_q, state_d;
	logic [gcl_pkg::CNT_W-1:0]      cnt_q, cnt_d;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		unique case (state_q)
			gcl_pkg::ST_IDLE: begin
				if (stat.line_done && stat.has_result) begin
					cmd.load = 1'b1;
					cnt_d    = '0;
					state_d  = gcl_pkg::ST_DIVIDE;
				end
			end
			gcl_pkg::ST_DIVIDE: begin
				cmd.first = (cnt_q == '0);
				cmd.step  = (cnt_q != '0);
				cnt_d     = cnt_q + 1'b1;
				if (cnt_q == gcl_pkg::CNT_W'(gcl_pkg::DIV_STEPS)) begin
					cnt_d   = '0;
					state_d = gcl_pkg::ST_DONE;
				end
			end
			gcl_pkg::ST_DONE: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = gcl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gcl_pkg::ST_IDLE;
			end
		endcase
	end

	// A line end in the first stage holds the stream so that its sums are
	// settled before the next line starts accumulating.
	assign in_ready = (state_q == gcl_pkg::ST_IDLE) && !stat.line_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gcl_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= gcl_pkg::CNT_W'(gcl_pkg::DIV_STEPS))
		else $error("division step counter out of range");
	a_busy_no_input: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !in_ready ##1 !in_ready)
		else $error("pixel stream accepted while the divider is loaded");
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("controller state is not one-hot");
`endif

endmodule

/* design/gcl_dp.sv */
// ----------------------------------------------------------------------------
// Gray centroid line centre: datapath
// Settings registers, pixel qualification, line accumulators, restoring
// divider and output register.
// ----------------------------------------------------------------------------
module gcl_dp #(
	parameter int FRACTION_BITS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_fire,
	input  logic [gcl_pkg::GRAY_W-1:0]      in_gray,
	input  logic [gcl_pkg::POS_W-1:0]       in_position,
	input  logic [gcl_pkg::LINE_W-1:0]      in_line_index,
	input  logic                            in_line_end,
	input  logic                            cfg_fire,
	input  logic [gcl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gcl_pkg::ROI_W-1:0]       cfg_data,
	input  logic                            out_ready,
	input  gcl_pkg::gcl_cmd_t               cmd,
	output gcl_pkg::gcl_stat_t              stat,
	output logic                            out_valid,
	output logic [gcl_pkg::CENT_W-1:0]      out_centroid,
	output logic [gcl_pkg::LINE_W-1:0]      out_line_number
);

	localparam int DW = gcl_pkg::WSUM_W + FRACTION_BITS;
	localparam int HW = DW - gcl_pkg::CENT_W;
	localparam int CW = (HW > gcl_pkg::CENT_W) ? HW : gcl_pkg::CENT_W;

	localparam int ROI_W  = gcl_pkg::ROI_W;
	localparam int CENT_W = gcl_pkg::CENT_W;
	localparam int WSUM_W = gcl_pkg::WSUM_W;
	localparam int GSUM_W = gcl_pkg::GSUM_W;
	localparam int PROD_W = gcl_pkg::PROD_W;
	localparam int GRAY_W = gcl_pkg::GRAY_W;

	// Settings registers.
	logic [GRAY_W-1:0] thr_q;
	logic              scan_cols_q;
	logic [ROI_W-1:0]  x_lo_q, x_hi_q, y_lo_q, y_hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= '0;
			scan_cols_q <= 1'b0;
			x_lo_q      <= '0;
			x_hi_q      <= gcl_pkg::ROI_HIGH_RESET;
			y_lo_q      <= '0;
			y_hi_q      <= gcl_pkg::ROI_HIGH_RESET;
		end else if (cfg_fire) begin
			unique case (cfg_index)
				gcl_pkg::REG_GRAY_THRESHOLD:  thr_q       <= cfg_data[GRAY_W-1:0];
				gcl_pkg::REG_SCAN_BY_COLUMNS: scan_cols_q <= cfg_data[0];
				gcl_pkg::REG_ROI_X_LOW:       x_lo_q      <= cfg_data;
				gcl_pkg::REG_ROI_X_HIGH:      x_hi_q      <= cfg_data;
				gcl_pkg::REG_ROI_Y_LOW:       y_lo_q      <= cfg_data;
				gcl_pkg::REG_ROI_Y_HIGH:      y_hi_q      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Input stage: region test, threshold and the gray by position product.
	logic [ROI_W-1:0]  x_pos, y_pos;
	logic              qual_d;
	logic [PROD_W-1:0] prod_d;

	always_comb begin
		if (scan_cols_q) begin
			x_pos = ROI_W'(in_line_index);
			y_pos = ROI_W'(in_position);
		end else begin
			x_pos = ROI_W'(in_position);
			y_pos = ROI_W'(in_line_index);
		end
		qual_d = (x_pos >= x_lo_q) && (x_pos <= x_hi_q)
			&& (y_pos >= y_lo_q) && (y_pos <= y_hi_q)
			&& (in_gray > thr_q)
			&& (17'(in_position) < gcl_pkg::MAX_LINE_LENGTH);
		prod_d = PROD_W'(in_gray) * PROD_W'(in_position);
	end

	logic                            valid_s1, last_s1, qual_s1;
	logic [PROD_W-1:0]               prod_s1;
	logic [GRAY_W-1:0]               gray_s1;
	logic [gcl_pkg::LINE_W-1:0]      line_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			last_s1 <= in_line_end;
			qual_s1 <= qual_d;
			prod_s1 <= prod_d;
			gray_s1 <= in_gray;
			line_s1 <= in_line_index;
		end
	end

	// Line accumulators, saturating at their full width.
	logic [WSUM_W-1:0] wsum_q, wsum_upd;
	logic [GSUM_W-1:0] gsum_q, gsum_upd;
	logic              any_q;
	logic [WSUM_W:0]   wsum_add;
	logic [GSUM_W:0]   gsum_add;

	always_comb begin
		wsum_add = (WSUM_W + 1)'(wsum_q) + (WSUM_W + 1)'(prod_s1);
		gsum_add = (GSUM_W + 1)'(gsum_q) + (GSUM_W + 1)'(gray_s1);
		wsum_upd = wsum_q;
		gsum_upd = gsum_q;
		if (qual_s1) begin
			wsum_upd = wsum_add[WSUM_W] ? '1 : wsum_add[WSUM_W-1:0];
			gsum_upd = gsum_add[GSUM_W] ? '1 : gsum_add[GSUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsum_q <= '0;
			gsum_q <= '0;
			any_q  <= 1'b0;
		end else if (valid_s1) begin
			if (last_s1) begin
				wsum_q <= '0;
				gsum_q <= '0;
				any_q  <= 1'b0;
			end else begin
				wsum_q <= wsum_upd;
				gsum_q <= gsum_upd;
				any_q  <= any_q | qual_s1;
			end
		end
	end

	assign stat.line_done  = valid_s1 && last_s1;
	assign stat.has_result = any_q || qual_s1;

	// Restoring divider. The first step checks whether the quotient fits in
	// the centroid width; the remainder then starts from the upper dividend
	// bits and the lower bits are shifted in one per step.
	logic [DW-1:0]                   dvd_q;
	logic [GSUM_W-1:0]               den_q;
	logic [CENT_W-1:0]               rem_q;
	logic [CENT_W-1:0]               quo_q;
	logic                            ovf_q;
	logic [gcl_pkg::LINE_W-1:0]      line_q;
	logic [CW-1:0]                   hi_ext;
	logic [CENT_W:0]                 trial, trial_sub;
	logic                            trial_ge;

	always_comb begin
		hi_ext    = CW'(dvd_q[DW-1:CENT_W]);
		trial     = {rem_q, dvd_q[CENT_W-1]};
		trial_sub = trial - (CENT_W + 1)'(den_q);
		trial_ge  = trial >= (CENT_W + 1)'(den_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dvd_q  <= DW'(wsum_upd) << FRACTION_BITS;
			den_q  <= gsum_upd;
			line_q <= line_s1;
		end else if (cmd.first) begin
			ovf_q <= hi_ext >= CW'(den_q);
			rem_q <= hi_ext[CENT_W-1:0];
		end else if (cmd.step) begin
			rem_q <= trial_ge ? trial_sub[CENT_W-1:0] : trial[CENT_W-1:0];
			quo_q <= {quo_q[CENT_W-2:0], trial_ge};
			dvd_q <= dvd_q << 1;
		end
	end

	// Output register.
	logic                       out_valid_q;
	logic [CENT_W-1:0]          cent_q;
	logic [gcl_pkg::LINE_W-1:0] line_num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			cent_q     <= ovf_q ? '1 : quo_q;
			line_num_q <= line_q;
		end
	end

	assign stat.out_free    = !out_valid_q || out_ready;
	assign out_valid        = out_valid_q;
	assign out_centroid     = cent_q;
	assign out_line_number  = line_num_q;

`ifndef SYNTHESIS
	a_load_on_line_end: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (valid_s1 && last_s1 && (any_q || qual_s1)))
		else $error("divider loaded without a qualifying line end");
	a_clear_after_line: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (gsum_q == '0) && !any_q)
		else $error("accumulators not cleared after a line end");
	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.emit))
		else $error("result shown without a finished division");
`endif

endmodule

/* design/gray_centroid_line_center.sv */
// ----------------------------------------------------------------------------
// Gray centroid line centre
// Gray-weighted centre of each scan line inside a region of interest.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake           payload
//  s_        in         s_tvalid/s_tready   s_tdata (gray, position, line_index),
//                                           s_tlast (line_end)
//  m_        out        m_tvalid/m_tready   m_tdata (centroid, line_number)
//  cfg_      in         cfg_valid/cfg_ready cfg_index, cfg_data
//
//  Pixels within a line are taken one item per cycle. After the last item of a
//  line, s_tready is low for one cycle, or, when the line yields a result, until
//  the shared restoring divider has loaded the line sums, run the quotient range
//  test, produced the twenty quotient bits one per step and handed the result over.
//  A stalled m_ side lengthens the hand-over until the output register frees up.
//  Reset clears the settings to their defaults and empties the accumulators.
//
module gray_centroid_line_center #(
	parameter int FRACTION_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,    // [7:0] gray, [19:8] position, [31:20] line_index
	input  logic        s_tlast,    // line_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,    // [19:0] centroid, [31:20] line_number
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	gcl_pkg::gcl_cmd_t               cmd;
	gcl_pkg::gcl_stat_t              stat;
	logic                            in_ready;
	logic [gcl_pkg::CENT_W-1:0]      centroid;
	logic [gcl_pkg::LINE_W-1:0]      line_number;

	gcl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.stat     (stat),
		.cmd      (cmd),
		.in_ready (in_ready)
	);

	gcl_dp #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_fire         (s_tvalid && in_ready),
		.in_gray         (s_tdata[7:0]),
		.in_position     (s_tdata[19:8]),
		.in_line_index   (s_tdata[31:20]),
		.in_line_end     (s_tlast),
		.cfg_fire        (cfg_valid),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.out_ready       (m_tready),
		.cmd             (cmd),
		.stat            (stat),
		.out_valid       (m_tvalid),
		.out_centroid    (centroid),
		.out_line_number (line_number)
	);

	assign s_tready  = in_ready;
	assign cfg_ready = 1'b1;
	assign m_tdata   = {line_number, centroid};

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gray centroid line centre: testbench
// Streams scan lines of pixels into the block under several region, threshold
// and scan-direction settings. Every accepted pixel also runs through a local
// model of the line accumulators. Each centroid the block returns is checked
// against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module testbench;

	localparam int GRAY_W    = gcl_pkg::GRAY_W;
	localparam int POS_W     = gcl_pkg::POS_W;
	localparam int LINE_W    = gcl_pkg::LINE_W;
	localparam int ROI_W     = gcl_pkg::ROI_W;
	localparam int WSUM_W    = gcl_pkg::WSUM_W;
	localparam int GSUM_W    = gcl_pkg::GSUM_W;
	localparam int CENT_W    = gcl_pkg::CENT_W;
	localparam int CFG_IDX_W = gcl_pkg::CFG_IDX_W;

	localparam int FRAC_BITS       = 8;
	localparam int HALF_PERIOD     = 5;
	localparam int SETTLE_CYCLES   = 30;
	localparam int HOLD_CYCLES     = 400;
	localparam int DRAIN_LIMIT     = 20000;
	localparam int LONG_PIXELS     = 120;
	localparam int PHASE_ITEMS     = 120;

	// Indexes past the last register; writes to them must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	localparam logic [63:0] WSUM_SAT = (64'd1 << WSUM_W) - 64'd1;
	localparam logic [63:0] GSUM_SAT = (64'd1 << GSUM_W) - 64'd1;
	localparam logic [63:0] CENT_SAT = (64'd1 << CENT_W) - 64'd1;

	typedef struct packed {
		logic [GRAY_W-1:0] gray;
		logic [POS_W-1:0]  pos;
		logic [LINE_W-1:0] line;
		logic              last;
	} pixel_t;

	typedef struct packed {
		logic [CENT_W-1:0] centroid;
		logic [LINE_W-1:0] line_number;
	} centre_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [31:0]       s_tdata   = '0;    // [7:0] gray, [19:8] position, [31:20] line_index
	logic              s_tlast   = 1'b0;  // line_end
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [31:0]       m_tdata;           // [19:0] centroid, [31:20] line_number
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [2:0]        cfg_index = '0;
	logic [12:0]       cfg_data  = '0;

	// Local copy of the settings and the line accumulators.
	logic [GRAY_W-1:0] threshold_reg = '0;
	logic              columns_reg   = 1'b0;
	logic [ROI_W-1:0]  x_low_reg     = '0;
	logic [ROI_W-1:0]  x_high_reg    = gcl_pkg::ROI_HIGH_RESET;
	logic [ROI_W-1:0]  y_low_reg     = '0;
	logic [ROI_W-1:0]  y_high_reg    = gcl_pkg::ROI_HIGH_RESET;
	logic [WSUM_W-1:0] line_weight_sum = '0;
	logic [GSUM_W-1:0] line_gray_sum   = '0;
	logic              line_has_pixel  = 1'b0;

	centre_t expected_centres[$];
	int      mismatch_count = 0;
	bit      steady = 1'b0;
	int      hold_requests = 0;
	int      holds_done = 0;

	gray_centroid_line_center #(.FRACTION_BITS(FRAC_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	function automatic pixel_t make_pixel(input logic [GRAY_W-1:0] gray,
			input logic [POS_W-1:0] pos, input logic [LINE_W-1:0] line, input logic last);
		pixel_t px;
		px.gray = gray;
		px.pos  = pos;
		px.line = line;
		px.last = last;
		return px;
	endfunction

	function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [ROI_W-1:0] value);
		case (idx)
			gcl_pkg::REG_GRAY_THRESHOLD:  threshold_reg = value[GRAY_W-1:0];
			gcl_pkg::REG_SCAN_BY_COLUMNS: columns_reg = value[0];
			gcl_pkg::REG_ROI_X_LOW:       x_low_reg = value;
			gcl_pkg::REG_ROI_X_HIGH:      x_high_reg = value;
			gcl_pkg::REG_ROI_Y_LOW:       y_low_reg = value;
			gcl_pkg::REG_ROI_Y_HIGH:      y_high_reg = value;
			default: ;
		endcase
	endfunction

	// Accumulates one accepted pixel and, at a line end, queues the centroid.
	function automatic void predict_centre(input pixel_t px);
		logic [ROI_W-1:0] x, y;
		logic [63:0] w, g, q;
		centre_t c;
		x = columns_reg ? ROI_W'(px.line) : ROI_W'(px.pos);
		y = columns_reg ? ROI_W'(px.pos) : ROI_W'(px.line);
		if (x >= x_low_reg && x <= x_high_reg && y >= y_low_reg && y <= y_high_reg
				&& px.gray > threshold_reg && 17'(px.pos) < gcl_pkg::MAX_LINE_LENGTH) begin
			w = 64'(line_weight_sum) + 64'(px.gray) * 64'(px.pos);
			g = 64'(line_gray_sum) + 64'(px.gray);
			line_weight_sum = (w > WSUM_SAT) ? WSUM_W'(WSUM_SAT) : WSUM_W'(w);
			line_gray_sum = (g > GSUM_SAT) ? GSUM_W'(GSUM_SAT) : GSUM_W'(g);
			line_has_pixel = 1'b1;
		end
		if (px.last) begin
			if (line_has_pixel && line_gray_sum != 0) begin
				q = (64'(line_weight_sum) << FRAC_BITS) / 64'(line_gray_sum);
				if (q > CENT_SAT)
					q = CENT_SAT;
				c.centroid = CENT_W'(q);
				c.line_number = px.line;
				expected_centres = {expected_centres, c};
			end
			line_weight_sum = '0;
			line_gray_sum = '0;
			line_has_pixel = 1'b0;
		end
	endfunction

	task automatic send_pixel(input pixel_t px);
		while (!steady && $urandom_range(99) < 28) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {px.line, px.pos, px.gray};
		s_tlast  <= px.last;
		do @(posedge clk); while (s_tready !== 1'b1);
		predict_centre(px);
	endtask

	// Stops offering pixels and waits until every predicted centroid is back.
	task automatic drain_results();
		int waited;
		waited = 0;
		s_tvalid <= 1'b0;
		do begin
			@(posedge clk);
			waited++;
		end while (expected_centres.size() != 0 && waited < DRAIN_LIMIT);
		if (expected_centres.size() != 0)
			report_mismatch("centroids never delivered", expected_centres.size(), 0);
	endtask

	// Leaves valid high; the caller lowers it after the last write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ROI_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		apply_write(idx, value);
	endtask

	// A line without a result may still be in the pipeline after the drain,
	// so the block is given its latency before the settings change.
	task automatic configure(input logic [ROI_W-1:0] thr, input logic [ROI_W-1:0] cols,
			input logic [ROI_W-1:0] xl, input logic [ROI_W-1:0] xh,
			input logic [ROI_W-1:0] yl, input logic [ROI_W-1:0] yh);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(gcl_pkg::REG_GRAY_THRESHOLD, thr);
		write_reg(gcl_pkg::REG_SCAN_BY_COLUMNS, cols);
		write_reg(gcl_pkg::REG_ROI_X_LOW, xl);
		write_reg(gcl_pkg::REG_ROI_X_HIGH, xh);
		write_reg(gcl_pkg::REG_ROI_Y_LOW, yl);
		write_reg(gcl_pkg::REG_ROI_Y_HIGH, yh);
		write_reg(REG_SPARE_6, ROI_W'($urandom));
		write_reg(REG_SPARE_7, ROI_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [POS_W-1:0] pick_coord(input logic [ROI_W-1:0] lo,
			input logic [ROI_W-1:0] hi);
		logic [ROI_W-1:0] top;
		top = (hi > 13'd4095) ? 13'd4095 : hi;
		if (lo <= top && $urandom_range(9) < 7)
			return POS_W'($urandom_range(32'(lo), 32'(top)));
		return POS_W'($urandom);
	endfunction

	function automatic void pick_range(output logic [ROI_W-1:0] lo, output logic [ROI_W-1:0] hi,
			input bit raw);
		if (raw) begin
			lo = ROI_W'($urandom);
			hi = ROI_W'($urandom);
		end else if ($urandom_range(7) == 0) begin
			hi = ROI_W'($urandom_range(0, 4000));
			lo = hi + ROI_W'($urandom_range(1, 96));
		end else begin
			lo = ROI_W'($urandom_range(0, 2048));
			hi = ROI_W'($urandom_range(32'(lo), 4096));
		end
	endfunction

	task automatic test_defaults();
		send_pixel(make_pixel(8'd255, 12'd0, 12'd0, 1'b1));
		// A gray of zero never exceeds the threshold, so this line is silent.
		send_pixel(make_pixel(8'd0, 12'd100, 12'd1, 1'b1));
		send_pixel(make_pixel(8'd255, 12'd4095, 12'd4095, 1'b1));
		send_pixel(make_pixel(8'd10, 12'd5, 12'd7, 1'b0));
		send_pixel(make_pixel(8'd20, 12'd6, 12'd7, 1'b0));
		send_pixel(make_pixel(8'd30, 12'd7, 12'd7, 1'b1));
		send_pixel(make_pixel(8'd1, 12'hAAA, 12'h555, 1'b1));
		send_pixel(make_pixel(8'h80, 12'h555, 12'hAAA, 1'b1));
	endtask

	task automatic test_registers();
		configure(13'd255, 13'd0, 13'd0, gcl_pkg::ROI_HIGH_RESET,
			13'd0, gcl_pkg::ROI_HIGH_RESET);
		send_pixel(make_pixel(8'd255, 12'd10, 12'd10, 1'b1));
		configure(13'd254, 13'd0, 13'd0, gcl_pkg::ROI_HIGH_RESET,
			13'd0, gcl_pkg::ROI_HIGH_RESET);
		send_pixel(make_pixel(8'd255, 12'd20, 12'd3, 1'b1));
		// In column mode the x bounds apply to the line index.
		configure(13'd0, 13'd1, 13'd100, 13'd200, 13'd0, gcl_pkg::ROI_HIGH_RESET);
		send_pixel(make_pixel(8'd40, 12'd10, 12'd150, 1'b0));
		send_pixel(make_pixel(8'd60, 12'd4095, 12'd150, 1'b1));
		send_pixel(make_pixel(8'd200, 12'd10, 12'd250, 1'b1));
		// Both bounds are inclusive; the outer neighbours must not count.
		configure(13'd0, 13'd0, 13'd100, 13'd200, 13'd50, 13'd50);
		send_pixel(make_pixel(8'd9, 12'd99, 12'd50, 1'b0));
		send_pixel(make_pixel(8'd17, 12'd100, 12'd50, 1'b0));
		send_pixel(make_pixel(8'd33, 12'd200, 12'd50, 1'b0));
		send_pixel(make_pixel(8'd65, 12'd201, 12'd50, 1'b1));
		send_pixel(make_pixel(8'd255, 12'd150, 12'd51, 1'b1));
		// An inverted region admits nothing.
		configure(13'd0, 13'd0, 13'd300, 13'd200, 13'd0, gcl_pkg::ROI_HIGH_RESET);
		send_pixel(make_pixel(8'd255, 12'd250, 12'd5, 1'b1));
		configure(13'd0, 13'd0, gcl_pkg::ROI_HIGH_RESET, gcl_pkg::ROI_HIGH_RESET,
			13'd0, gcl_pkg::ROI_HIGH_RESET);
		send_pixel(make_pixel(8'd255, 12'd4095, 12'd5, 1'b1));
	endtask

	// A long line of the brightest pixels at the far end of the line, which
	// puts the centroid at the top of its unsaturated range.
	task automatic test_long_line();
		configure(13'd0, 13'd0, 13'd0, gcl_pkg::ROI_HIGH_RESET,
			13'd0, gcl_pkg::ROI_HIGH_RESET);
		for (int i = 0; i < LONG_PIXELS; i++)
			send_pixel(make_pixel(8'd255, 12'd4095, 12'd77, i == LONG_PIXELS - 1));
	endtask

	task automatic test_backpressure();
		configure(13'd0, 13'd0, 13'd0, gcl_pkg::ROI_HIGH_RESET,
			13'd0, gcl_pkg::ROI_HIGH_RESET);
		hold_requests++;
		for (int i = 0; i < 16; i++) begin
			send_pixel(make_pixel(GRAY_W'($urandom_range(1, 255)), POS_W'($urandom),
				LINE_W'(i), 1'b0));
			send_pixel(make_pixel(GRAY_W'($urandom_range(1, 255)), POS_W'($urandom),
				LINE_W'(i), 1'b1));
		end
		drain_results();
	endtask

	// Mostly proper lines aimed at the region, with some scattered noise.
	task automatic random_phase(input int items);
		int sent;
		int len;
		logic [LINE_W-1:0] line_no;
		logic [POS_W-1:0] p;
		logic [ROI_W-1:0] line_lo, line_hi, pos_lo, pos_hi;
		sent = 0;
		line_lo = columns_reg ? x_low_reg : y_low_reg;
		line_hi = columns_reg ? x_high_reg : y_high_reg;
		pos_lo = columns_reg ? y_low_reg : x_low_reg;
		pos_hi = columns_reg ? y_high_reg : x_high_reg;
		while (sent < items) begin
			if ($urandom_range(99) < 85) begin
				len = $urandom_range(1, 12);
				line_no = pick_coord(line_lo, line_hi);
				p = pick_coord(pos_lo, pos_hi);
				for (int i = 0; i < len; i++) begin
					send_pixel(make_pixel(GRAY_W'($urandom), p, line_no, i == len - 1));
					p++;
				end
			end else begin
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++)
					send_pixel(make_pixel(GRAY_W'($urandom), POS_W'($urandom),
						LINE_W'($urandom), i == len - 1));
			end
			sent += len;
			if ($urandom_range(11) == 0)
				drain_results();
		end
	endtask

	task automatic test_random();
		logic [ROI_W-1:0] xl, xh, yl, yh, thr;
		configure(13'd0, 13'd0, 13'd0, gcl_pkg::ROI_HIGH_RESET,
			13'd0, gcl_pkg::ROI_HIGH_RESET);
		random_phase(PHASE_ITEMS);
		for (int ph = 1; ph < 6; ph++) begin
			pick_range(xl, xh, ph == 4);
			pick_range(yl, yh, 1'b0);
			if (ph == 4)
				thr = ROI_W'($urandom);
			else if (ph == 5)
				thr = ROI_W'($urandom_range(200, 255));
			else
				thr = ROI_W'($urandom_range(0, 80));
			configure(thr, ROI_W'($urandom_range(1)), xl, xh, yl, yh);
			steady = (ph == 2);
			random_phase(PHASE_ITEMS);
			steady = 1'b0;
		end
	endtask

	// Sink side; a requested hold-off keeps tready low.
	initial begin
		forever begin
			@(posedge clk);
			if (holds_done != hold_requests) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done++;
			end else begin
				m_tready <= steady || ($urandom_range(99) >= 28);
			end
		end
	end

	always @(posedge clk) begin : check_centres
		centre_t want;
		if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
			if (expected_centres.size() == 0) begin
				report_mismatch("centroid without a pending line", m_tdata[CENT_W-1:0], 0);
			end else begin
				want = expected_centres.pop_front();
				if (m_tdata[CENT_W-1:0] !== want.centroid)
					report_mismatch("centroid", m_tdata[CENT_W-1:0], want.centroid);
				if (m_tdata[CENT_W +: LINE_W] !== want.line_number)
					report_mismatch("line_number", m_tdata[CENT_W +: LINE_W], want.line_number);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("testbench: done, errors");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_registers();
		test_long_line();
		test_backpressure();
		test_random();
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

/* sim.f */
design/gcl_pkg.sv
design/gcl_ctrl.sv
design/gcl_dp.sv
design/gray_centroid_line_center.sv
sim/testbench.sv
